>>> hw/rtl/mlp_pkg.sv
// Shared constants, control structs and the sigmoid lookup table for the
// two-layer perceptron block. No dependencies.
`default_nettype none

package mlp_pkg;

  localparam int HIDDEN_UNITS = 16;
  localparam int FEAT_CNT     = 8;
  localparam int OUT_CNT      = 2;
  localparam int SIG_DEPTH    = 1024;

  localparam int STORE_DEPTH = 256;
  localparam int STORE_AW    = 8;
  // layout addresses reach past the store for large hidden counts
  localparam int LA_W        = STORE_AW + 1;

  localparam int W_W    = 16;
  localparam int ACT_W  = 16;
  localparam int OPA_W  = 17;
  localparam int PROD_W = 34;
  localparam int ACC_W  = 40;

  localparam int HID_IW    = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
  localparam int FEAT_IW   = $clog2(FEAT_CNT);
  localparam int MAX_TERMS = (FEAT_CNT > HIDDEN_UNITS) ? FEAT_CNT : HIDDEN_UNITS;
  localparam int TERM_W    = $clog2(MAX_TERMS + 1);
  localparam int OUT_LAST  = OUT_CNT - 1;

  localparam int B1_BASE = FEAT_CNT * HIDDEN_UNITS;
  localparam int W2_BASE = 9 * HIDDEN_UNITS;
  localparam int B2_BASE = 11 * HIDDEN_UNITS;

  localparam int L1_FRAC  = 24;
  localparam int L2_FRAC  = 28;
  localparam int B1_SHIFT = 12;
  localparam int B2_SHIFT = 16;

  localparam int SIG_IW    = $clog2(SIG_DEPTH);
  localparam int U_W       = 33;
  localparam int X_W       = U_W + SIG_IW + 1;
  localparam int N_W       = $clog2(5 * (SIG_DEPTH - 1) + 3);
  localparam int RECIP5    = 52429;
  localparam int RECIP5_SH = 18;
  localparam int RECIP_W   = 16;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_EVAL  = 1'b1;

  typedef struct packed {
    logic              valid;
    logic              first;
    logic              last;
    logic              layer2;
    logic              zero_w;
    logic [HID_IW-1:0] dest;
  } mac_ctl_t;

  typedef struct packed {
    logic              valid;
    logic              layer2;
    logic [HID_IW-1:0] dest;
  } act_tag_t;

  typedef logic [ACT_W-1:0] sig_lut_t [SIG_DEPTH];

  // Unsigned quotient by restoring long division, used while the table is built.
  function automatic longint unsigned udiv64(longint unsigned num,
                                             longint unsigned dvs);
    longint unsigned quo;
    longint unsigned rem;
    quo = 0;
    rem = 0;
    for (int i = 63; i >= 0; i--) begin
      rem = (rem << 1) | ((num >> i) & 64'd1);
      quo = quo << 1;
      if (rem >= dvs) begin
        rem = rem - dvs;
        quo = quo | 64'd1;
      end
    end
    return quo;
  endfunction

  // Entry k holds sigmoid(-10 + 20k/(D-1)) in Q0.16, evaluated at elaboration.
  function automatic sig_lut_t build_sig_lut();
    sig_lut_t          lut;
    longint unsigned   dm1;
    longint unsigned   a;
    longint unsigned   b;
    longint unsigned   mag;
    longint unsigned   t;
    longint unsigned   s;
    longint unsigned   term;
    longint unsigned   r;
    longint unsigned   den;
    longint unsigned   y;
    longint            sum;
    longint unsigned   one;
    logic              neg;
    dm1 = longint'(SIG_DEPTH - 1);
    one = 64'd1 << 30;
    for (int k = 0; k < SIG_DEPTH; k++) begin
      a   = 64'd20 * longint'(k);
      b   = 64'd10 * dm1;
      neg = (a < b);
      mag = neg ? (b - a) : (a - b);
      t   = udiv64(mag << 30, dm1);
      s   = t >> 4;
      term = one;
      sum  = longint'(one);
      for (int n = 1; n <= 12; n++) begin
        term = udiv64((term * s) >> 30, longint'(n));
        if ((n & 1) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      r = longint'(sum);
      if (r > one) begin
        r = one;
      end
      for (int q = 0; q < 4; q++) begin
        r = (r * r) >> 30;
      end
      den = one + r;
      if (neg) begin
        y = udiv64((r << 16) + (den >> 1), den);
      end else begin
        y = udiv64((one << 16) + (den >> 1), den);
      end
      if (y > 64'd65535) begin
        y = 64'd65535;
      end
      lut[k] = y[ACT_W-1:0];
    end
    return lut;
  endfunction

  localparam sig_lut_t SIG_LUT = build_sig_lut();

endpackage

`default_nettype wire

>>> hw/rtl/mlp_two_layer_sigmoid_inference.sv
// Top level of the two-layer sigmoid perceptron: sequencer, feature and
// hidden activation registers. Depends on mlp_pkg, mlp_param_store,
// mlp_mac and mlp_act.
//
// Usage:
//   Items enter on start while busy is low. A write item (in_kind = 0) puts
//   in_param_value into the parameter store at in_param_index and gives no
//   result; busy stays low. An evaluate item (in_kind = 1) latches the eight
//   features and raises busy.
//   One multiply-accumulate pipeline handles every product, one term per
//   cycle: (FEAT_CNT+1) terms per hidden unit, then (HIDDEN_UNITS+1) per
//   output, with the sigmoid pipeline trailing the accumulator. The layers
//   are separated by a drain of the pipelines.
//   busy falls together with the out_valid strobe, so the next item can be
//   accepted in the strobe cycle.
//   out_a and out_b are valid for exactly the one cycle out_valid is high;
//   the receiver cannot stall.
//   Reset (rst_n low, synchronous) returns to idle and drops any evaluation
//   in flight; the parameter store keeps its contents and is undefined until
//   written.
`default_nettype none

module mlp_two_layer_sigmoid_inference
  import mlp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_kind,
  input  wire logic [7:0]  in_param_index,
  input  wire logic [15:0] in_param_value,
  input  wire logic [15:0] in_feature_0,
  input  wire logic [15:0] in_feature_1,
  input  wire logic [15:0] in_feature_2,
  input  wire logic [15:0] in_feature_3,
  input  wire logic [15:0] in_feature_4,
  input  wire logic [15:0] in_feature_5,
  input  wire logic [15:0] in_feature_6,
  input  wire logic [15:0] in_feature_7,
  output logic             out_valid,
  output logic [15:0]      out_a,
  output logic [15:0]      out_b
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_L1    = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_L2    = 3'd3;
  localparam logic [2:0] ST_WAIT  = 3'd4;

  logic [2:0]        state_r;
  logic [2:0]        state_nxt;
  logic [TERM_W-1:0] term_r;
  logic [TERM_W-1:0] term_nxt;
  logic [HID_IW-1:0] unit_r;
  logic [HID_IW-1:0] unit_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;

  logic [W_W-1:0]   feature_r [FEAT_CNT];
  logic [W_W-1:0]   in_feat [FEAT_CNT];
  logic [ACT_W-1:0] hidden_r [HIDDEN_UNITS];
  logic [ACT_W-1:0] out_a_r;
  logic [ACT_W-1:0] out_b_r;

  logic              accept;
  logic              eval_accept;
  logic              issuing;
  logic              layer2;
  logic              term_last;
  logic [TERM_W-1:0] jm1;
  logic [LA_W-1:0]   la;
  mac_ctl_t          issue_ctl;
  logic signed [OPA_W-1:0] issue_opa;

  logic [W_W-1:0]          w_data;
  logic signed [ACC_W-1:0] acc;
  act_tag_t                done_tag;
  act_tag_t                act_tag;
  logic [ACT_W-1:0]        act_val;
  logic                    mac_busy;
  logic                    act_busy;
  logic                    final_out;

  assign in_feat[0] = in_feature_0;
  assign in_feat[1] = in_feature_1;
  assign in_feat[2] = in_feature_2;
  assign in_feat[3] = in_feature_3;
  assign in_feat[4] = in_feature_4;
  assign in_feat[5] = in_feature_5;
  assign in_feat[6] = in_feature_6;
  assign in_feat[7] = in_feature_7;

  assign busy        = (state_r != ST_IDLE);
  assign accept      = start & ~busy;
  assign eval_accept = accept & (in_kind == KIND_EVAL);

  assign issuing   = (state_r == ST_L1) | (state_r == ST_L2);
  assign layer2    = (state_r == ST_L2);
  assign term_last = layer2 ? (term_r == TERM_W'(HIDDEN_UNITS))
                            : (term_r == TERM_W'(FEAT_CNT));
  assign jm1       = (term_r == '0) ? '0 : term_r - 1'b1;

  // term 0 fetches the bias, term j+1 the weight of input j
  always_comb begin
    if (term_r == '0) begin
      la = (layer2 ? LA_W'(B2_BASE) : LA_W'(B1_BASE)) + LA_W'(unit_r);
    end else if (layer2) begin
      la = LA_W'(W2_BASE) + LA_W'(jm1) * LA_W'(OUT_CNT) + LA_W'(unit_r);
    end else begin
      la = LA_W'(jm1) * LA_W'(HIDDEN_UNITS) + LA_W'(unit_r);
    end
  end

  always_comb begin
    if (layer2) begin
      issue_opa = $signed({1'b0, hidden_r[jm1[HID_IW-1:0]]});
    end else begin
      issue_opa = $signed({feature_r[jm1[FEAT_IW-1:0]][W_W-1],
                           feature_r[jm1[FEAT_IW-1:0]]});
    end
    issue_ctl.valid  = issuing;
    issue_ctl.first  = (term_r == '0);
    issue_ctl.last   = term_last;
    issue_ctl.layer2 = layer2;
    issue_ctl.zero_w = la[LA_W-1];
    issue_ctl.dest   = unit_r;
  end

  assign final_out = act_tag.valid & act_tag.layer2 & (act_tag.dest == HID_IW'(OUT_LAST));

  always_comb begin
    state_nxt     = state_r;
    term_nxt      = term_r;
    unit_nxt      = unit_r;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (eval_accept) begin
          state_nxt = ST_L1;
          term_nxt  = '0;
          unit_nxt  = '0;
        end
      end
      ST_L1: begin
        if (term_last) begin
          term_nxt = '0;
          if (unit_r == HID_IW'(HIDDEN_UNITS - 1)) begin
            unit_nxt  = '0;
            state_nxt = ST_DRAIN;
          end else begin
            unit_nxt = unit_r + 1'b1;
          end
        end else begin
          term_nxt = term_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        // hold until every hidden activation has landed
        if (!mac_busy && !act_busy) begin
          state_nxt = ST_L2;
        end
      end
      ST_L2: begin
        if (term_last) begin
          term_nxt = '0;
          if (unit_r == HID_IW'(OUT_LAST)) begin
            unit_nxt  = '0;
            state_nxt = ST_WAIT;
          end else begin
            unit_nxt = unit_r + 1'b1;
          end
        end else begin
          term_nxt = term_r + 1'b1;
        end
      end
      ST_WAIT: begin
        if (final_out) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      term_r      <= '0;
      unit_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      term_r      <= term_nxt;
      unit_r      <= unit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (eval_accept) begin
      for (int f = 0; f < FEAT_CNT; f++) begin
        feature_r[f] <= in_feat[f];
      end
    end
    if (act_tag.valid && !act_tag.layer2) begin
      hidden_r[act_tag.dest] <= act_val;
    end
    if (act_tag.valid && act_tag.layer2 && act_tag.dest == '0) begin
      out_a_r <= act_val;
    end
    if (final_out) begin
      out_b_r <= act_val;
    end
  end

  mlp_param_store u_store (
    .clk     (clk),
    .wr_en   (accept & (in_kind == KIND_WRITE)),
    .wr_addr (in_param_index),
    .wr_data (in_param_value),
    .rd_addr (la[STORE_AW-1:0]),
    .rd_data (w_data)
  );

  mlp_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_in   (issue_ctl),
    .opa_in   (issue_opa),
    .w_data   (w_data),
    .acc      (acc),
    .done_tag (done_tag),
    .busy     (mac_busy)
  );

  mlp_act u_act (
    .clk     (clk),
    .rst_n   (rst_n),
    .tag_in  (done_tag),
    .acc_in  (acc),
    .tag_out (act_tag),
    .act_out (act_val),
    .busy    (act_busy)
  );

  assign out_valid = out_valid_r;
  assign out_a     = out_a_r;
  assign out_b     = out_b_r;

endmodule

`default_nettype wire

>>> hw/rtl/mlp_param_store.sv
// Weight and bias store: 256 x 16 single-port-write, registered-read memory.
// Depends on mlp_pkg.
`default_nettype none

module mlp_param_store
  import mlp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                wr_en,
  input  wire logic [STORE_AW-1:0] wr_addr,
  input  wire logic [W_W-1:0]      wr_data,
  input  wire logic [STORE_AW-1:0] rd_addr,
  output logic      [W_W-1:0]      rd_data
);

  logic [W_W-1:0] mem [STORE_DEPTH];
  logic [W_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> hw/rtl/mlp_mac.sv
// Shared multiply-accumulate pipeline: operand stage, product stage and
// 40-bit accumulator. Depends on mlp_pkg.
`default_nettype none

module mlp_mac
  import mlp_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire mac_ctl_t                ctl_in,
  input  wire logic signed [OPA_W-1:0] opa_in,
  input  wire logic        [W_W-1:0]   w_data,
  output logic signed      [ACC_W-1:0] acc,
  output act_tag_t                     done_tag,
  output logic                         busy
);

  mac_ctl_t                  ctl1_r;
  mac_ctl_t                  ctl2_r;
  mac_ctl_t                  ctl3_r;
  logic signed [OPA_W-1:0]   opa_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [PROD_W-1:0]  prod_nxt;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACC_W-1:0]   acc_nxt;
  logic signed [W_W-1:0]     w;
  logic signed [PROD_W-1:0]  w_ext;
  logic signed [OPA_W+W_W-1:0] mul;

  always_comb begin
    w     = ctl1_r.zero_w ? '0 : $signed(w_data);
    w_ext = {{(PROD_W-W_W){w[W_W-1]}}, w};
    mul   = (OPA_W+W_W)'(opa_r) * (OPA_W+W_W)'(w);
    if (ctl1_r.first) begin
      // bias enters aligned to the layer's product scale
      prod_nxt = ctl1_r.layer2 ? (w_ext <<< B2_SHIFT) : (w_ext <<< B1_SHIFT);
    end else begin
      prod_nxt = {{(PROD_W-OPA_W-W_W){mul[OPA_W+W_W-1]}}, mul};
    end
  end

  always_comb begin
    if (ctl2_r.first) begin
      acc_nxt = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end else begin
      acc_nxt = acc_r + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
      acc_r  <= '0;
    end else begin
      ctl1_r <= ctl_in;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
      if (ctl2_r.valid) begin
        acc_r <= acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    opa_r  <= opa_in;
    prod_r <= prod_nxt;
  end

  assign acc             = acc_r;
  assign done_tag.valid  = ctl3_r.valid & ctl3_r.last;
  assign done_tag.layer2 = ctl3_r.layer2;
  assign done_tag.dest   = ctl3_r.dest;
  assign busy            = ctl1_r.valid | ctl2_r.valid | ctl3_r.valid;

endmodule

`default_nettype wire

>>> hw/rtl/mlp_act.sv
// Sigmoid activation pipeline: clamp, table index scaling, divide by five,
// registered table read. Depends on mlp_pkg (SIG_LUT).
`default_nettype none

module mlp_act
  import mlp_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire act_tag_t                tag_in,
  input  wire logic signed [ACC_W-1:0] acc_in,
  output act_tag_t                     tag_out,
  output logic             [ACT_W-1:0] act_out,
  output logic                         busy
);

  localparam logic signed [ACC_W-1:0] LIM_L1 = ACC_W'(10) << L1_FRAC;
  localparam logic signed [ACC_W-1:0] LIM_L2 = ACC_W'(10) << L2_FRAC;
  localparam logic [X_W-1:0] HALF_L1 = X_W'(10) << L1_FRAC;
  localparam logic [X_W-1:0] HALF_L2 = X_W'(10) << L2_FRAC;
  localparam int Q_W = N_W + RECIP_W;

  act_tag_t              tag_a_r;
  act_tag_t              tag_b_r;
  act_tag_t              tag_c_r;
  act_tag_t              tag_d_r;
  logic [U_W-1:0]        u_r;
  logic [N_W-1:0]        n_r;
  logic [SIG_IW-1:0]     k_r;
  logic [ACT_W-1:0]      rom_r;

  logic signed [ACC_W-1:0] lim;
  logic signed [ACC_W-1:0] vc;
  logic signed [ACC_W-1:0] u_full;
  logic [U_W-1:0]          u_nxt;
  logic [X_W-1:0]          x;
  logic [X_W-1:0]          x_sh;
  logic [N_W-1:0]          n_nxt;
  logic [Q_W-1:0]          q_prod;
  logic [Q_W-1:0]          q;
  logic [SIG_IW-1:0]       k_nxt;

  // clamp to +-10 and offset to an unsigned distance from -10
  always_comb begin
    lim = tag_in.layer2 ? LIM_L2 : LIM_L1;
    priority if (acc_in > lim) begin
      vc = lim;
    end else if (acc_in < -lim) begin
      vc = -lim;
    end else begin
      vc = acc_in;
    end
    u_full = vc + lim;
    u_nxt  = u_full[U_W-1:0];
  end

  // (u*(D-1) + 10*2^F) / (5*2^(F+2)): power-of-two part here
  always_comb begin
    x = X_W'(u_r) * X_W'(SIG_DEPTH - 1) + (tag_a_r.layer2 ? HALF_L2 : HALF_L1);
    x_sh  = tag_a_r.layer2 ? (x >> (L2_FRAC + 2)) : (x >> (L1_FRAC + 2));
    n_nxt = x_sh[N_W-1:0];
  end

  // divide by five through a reciprocal multiply
  always_comb begin
    q_prod = Q_W'(n_r) * Q_W'(RECIP5);
    q      = q_prod >> RECIP5_SH;
    if (q > Q_W'(SIG_DEPTH - 1)) begin
      k_nxt = SIG_IW'(SIG_DEPTH - 1);
    end else begin
      k_nxt = q[SIG_IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_a_r <= '0;
      tag_b_r <= '0;
      tag_c_r <= '0;
      tag_d_r <= '0;
    end else begin
      tag_a_r <= tag_in;
      tag_b_r <= tag_a_r;
      tag_c_r <= tag_b_r;
      tag_d_r <= tag_c_r;
    end
  end

  always_ff @(posedge clk) begin
    u_r   <= u_nxt;
    n_r   <= n_nxt;
    k_r   <= k_nxt;
    rom_r <= SIG_LUT[k_r];
  end

  assign tag_out = tag_d_r;
  assign act_out = rom_r;
  assign busy    = tag_a_r.valid | tag_b_r.valid | tag_c_r.valid | tag_d_r.valid;

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for mlp_two_layer_sigmoid_inference: parameter loads and
// network evaluations, checked against an in-bench fixed-point model of the network.
// Depends on mlp_pkg and the block's RTL.

module testbench
  import mlp_pkg::*;
();

  localparam int STORE_WORDS   = 256;
  localparam int BIAS1_ADDR    = 8 * HIDDEN_UNITS;
  localparam int WEIGHT2_ADDR  = 9 * HIDDEN_UNITS;
  localparam int BIAS2_ADDR    = 11 * HIDDEN_UNITS;
  localparam int LAYOUT_WORDS  = 11 * HIDDEN_UNITS + 2;
  localparam int EVAL_LATENCY  = 9 * HIDDEN_UNITS + 2 * (HIDDEN_UNITS + 1) + 15;
  localparam int PHASE_ITEMS   = 288;
  localparam longint unsigned Q30 = 64'd1 << 30;

  typedef logic [15:0] feat_vec_t [8];

  typedef struct {
    logic [15:0] a;
    logic [15:0] b;
  } out_pair_t;

  typedef enum int {SPAN_FULL, SPAN_TWO, SPAN_HALF, SPAN_EDGE} value_span_t;

  class perceptron_checker;
    logic [15:0] store [STORE_WORDS];
    logic [15:0] hidden [HIDDEN_UNITS];
    logic [15:0] sigmoid_rom [SIG_DEPTH];
    out_pair_t   expected_outputs [$];
    int          errors;

    function new();
      longint unsigned span, mag, s, term, r, den, y;
      longint          acc;
      logic            below;
      errors = 0;
      foreach (store[a]) store[a] = '0;
      span = longint'(SIG_DEPTH - 1);
      for (int k = 0; k < SIG_DEPTH; k++) begin
        below = (64'd20 * k) < (64'd10 * span);
        mag   = below ? 64'd10 * span - 64'd20 * k : 64'd20 * k - 64'd10 * span;
        s     = ((mag << 30) / span) >> 4;
        // exp(-s) by a truncated series, then raised to the 16th power
        term  = Q30;
        acc   = longint'(Q30);
        for (int n = 1; n <= 12; n++) begin
          term = ((term * s) >> 30) / longint'(n);
          if (n % 2 == 1) acc = acc - longint'(term);
          else acc = acc + longint'(term);
        end
        if (acc < 0) acc = 0;
        r = longint'(acc);
        if (r > Q30) r = Q30;
        repeat (4) r = (r * r) >> 30;
        den = Q30 + r;
        y   = below ? ((r << 16) + den / 2) / den : ((Q30 << 16) + den / 2) / den;
        if (y > 64'd65535) y = 64'd65535;
        sigmoid_rom[k] = y[15:0];
      end
    endfunction

    function longint weight_at(int addr);
      if (addr >= STORE_WORDS) return 0;
      return longint'(signed'(store[addr]));
    endfunction

    // clamp to +/-10 and round to the nearest table entry
    function logic [15:0] squash(longint v, int frac);
      longint          lim;
      longint unsigned u, k;
      lim = longint'(10) << frac;
      if (v > lim) v = lim;
      if (v < -lim) v = -lim;
      u = longint'(v + lim);
      k = (u * longint'(SIG_DEPTH - 1) + longint'(lim)) / longint'(2 * lim);
      if (k > SIG_DEPTH - 1) k = SIG_DEPTH - 1;
      return sigmoid_rom[k];
    endfunction

    function out_pair_t predict_outputs(feat_vec_t fv);
      longint    sum;
      out_pair_t res;
      for (int i = 0; i < HIDDEN_UNITS; i++) begin
        sum = weight_at(BIAS1_ADDR + i) * 4096;
        for (int j = 0; j < 8; j++)
          sum += longint'(signed'(fv[j])) * weight_at(j * HIDDEN_UNITS + i);
        hidden[i] = squash(sum, 24);
      end
      for (int o = 0; o < 2; o++) begin
        sum = weight_at(BIAS2_ADDR + o) * 65536;
        for (int j = 0; j < HIDDEN_UNITS; j++)
          sum += longint'(hidden[j]) * weight_at(WEIGHT2_ADDR + 2 * j + o);
        if (o == 0) res.a = squash(sum, 28);
        else res.b = squash(sum, 28);
      end
      return res;
    endfunction

    function void note_item(logic kind, logic [7:0] idx, logic [15:0] val, feat_vec_t fv);
      if (kind == KIND_WRITE) store[idx] = val;
      else expected_outputs.push_back(predict_outputs(fv));
    endfunction

    function void check_result(logic [15:0] a, logic [15:0] b);
      out_pair_t want;
      if (expected_outputs.size() == 0) begin
        $error("result with no evaluation pending: out_a=%0d out_b=%0d", a, b);
        errors++;
      end else begin
        want = expected_outputs.pop_front();
        if (a !== want.a) begin
          $error("out_a mismatch: expected %0d, got %0d", want.a, a);
          errors++;
        end
        if (b !== want.b) begin
          $error("out_b mismatch: expected %0d, got %0d", want.b, b);
          errors++;
        end
      end
    endfunction

    function int pending_count();
      return expected_outputs.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_kind;
  logic [7:0]  in_param_index;
  logic [15:0] in_param_value;
  logic [15:0] in_feature_0, in_feature_1, in_feature_2, in_feature_3;
  logic [15:0] in_feature_4, in_feature_5, in_feature_6, in_feature_7;
  logic        out_valid;
  logic [15:0] out_a;
  logic [15:0] out_b;

  perceptron_checker sb;
  feat_vec_t         seen_features;
  int                idle_pct;

  mlp_two_layer_sigmoid_inference uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_kind        (in_kind),
    .in_param_index (in_param_index),
    .in_param_value (in_param_value),
    .in_feature_0   (in_feature_0),
    .in_feature_1   (in_feature_1),
    .in_feature_2   (in_feature_2),
    .in_feature_3   (in_feature_3),
    .in_feature_4   (in_feature_4),
    .in_feature_5   (in_feature_5),
    .in_feature_6   (in_feature_6),
    .in_feature_7   (in_feature_7),
    .out_valid      (out_valid),
    .out_a          (out_a),
    .out_b          (out_b)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // check the result first: the next item may be accepted in the strobe cycle
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_a, out_b);
      if (start && !busy) begin
        seen_features = '{in_feature_0, in_feature_1, in_feature_2, in_feature_3,
                          in_feature_4, in_feature_5, in_feature_6, in_feature_7};
        sb.note_item(in_kind, in_param_index, in_param_value, seen_features);
      end
    end
  end

  function automatic logic [15:0] draw_word(value_span_t span);
    case (span)
      SPAN_FULL: return 16'($urandom);
      SPAN_TWO:  return 16'($urandom_range(0, 16384) - 8192);
      SPAN_HALF: return 16'($urandom_range(0, 4096) - 2048);
      default: begin
        case ($urandom_range(0, 6))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h0000;
          3: return 16'hFFFF;
          4: return 16'h0001;
          5: return 16'h1000;
          default: return 16'hF000;
        endcase
      end
    endcase
  endfunction

  function automatic logic [15:0] random_weight();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return draw_word(SPAN_HALF);
    if (r < 80) return draw_word(SPAN_TWO);
    if (r < 92) return draw_word(SPAN_FULL);
    return draw_word(SPAN_EDGE);
  endfunction

  function automatic feat_vec_t random_features(int mode);
    feat_vec_t fv;
    foreach (fv[j]) begin
      if (mode < 70) fv[j] = draw_word(SPAN_TWO);
      else if (mode < 85) fv[j] = draw_word(SPAN_FULL);
      else fv[j] = draw_word(value_span_t'($urandom_range(0, 3)));
    end
    return fv;
  endfunction

  // present one item at a falling edge and hold it until accepted
  task automatic send_item(input logic kind, input logic [7:0] idx,
                           input logic [15:0] val, input feat_vec_t fv);
    @(negedge clk);
    if (idle_pct != 0) begin
      if ($urandom_range(0, 1) == 0) begin
        while (busy) begin
          start <= 1'b0;
          @(negedge clk);
        end
      end
      while ($urandom_range(0, 99) < idle_pct) begin
        start <= 1'b0;
        @(negedge clk);
      end
    end
    in_kind        <= kind;
    in_param_index <= idx;
    in_param_value <= val;
    in_feature_0   <= fv[0];
    in_feature_1   <= fv[1];
    in_feature_2   <= fv[2];
    in_feature_3   <= fv[3];
    in_feature_4   <= fv[4];
    in_feature_5   <= fv[5];
    in_feature_6   <= fv[6];
    in_feature_7   <= fv[7];
    start          <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // features are ignored by a write: fill them with noise
  task automatic write_word(input int addr, input logic [15:0] val);
    send_item(KIND_WRITE, 8'(addr), val, random_features(80));
  endtask

  // param fields are ignored by an evaluation: fill them with noise
  task automatic evaluate(input feat_vec_t fv);
    send_item(KIND_EVAL, 8'($urandom), 16'($urandom), fv);
  endtask

  task automatic drain_results(input int limit);
    int n;
    n = 0;
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending_count() != 0 && n < limit) begin
      @(posedge clk);
      n++;
    end
  endtask

  initial begin
    feat_vec_t fv;
    int        phase_idle [4];
    int        done;
    int        burst;
    sb = new();
    rst_n          = 1'b0;
    start          = 1'b0;
    in_kind        = KIND_WRITE;
    in_param_index = '0;
    in_param_value = '0;
    in_feature_0   = '0;
    in_feature_1   = '0;
    in_feature_2   = '0;
    in_feature_3   = '0;
    in_feature_4   = '0;
    in_feature_5   = '0;
    in_feature_6   = '0;
    in_feature_7   = '0;
    idle_pct       = 0;
    phase_idle     = '{0, 67, 0, 31};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // every word the layout reads is written before the first evaluation
    for (int a = 0; a < LAYOUT_WORDS; a++) write_word(a, draw_word(SPAN_HALF));

    foreach (fv[j]) fv[j] = 16'h0000;
    evaluate(fv);
    foreach (fv[j]) fv[j] = 16'h7FFF;
    evaluate(fv);
    foreach (fv[j]) fv[j] = 16'h8000;
    evaluate(fv);
    foreach (fv[j]) fv[j] = (j % 2 == 0) ? 16'h7FFF : 16'h8000;
    evaluate(fv);
    write_word(255, 16'h8000);
    write_word(0, 16'h7FFF);
    write_word(BIAS1_ADDR, 16'h7FFF);
    foreach (fv[j]) fv[j] = 16'h7FFF;
    evaluate(fv);
    foreach (fv[j]) fv[j] = 16'h8000;
    evaluate(fv);
    write_word(BIAS2_ADDR, 16'h8000);
    write_word(BIAS2_ADDR + 1, 16'h7FFF);
    foreach (fv[j]) fv[j] = 16'h0000;
    evaluate(fv);
    write_word(WEIGHT2_ADDR, 16'h7FFF);
    foreach (fv[j]) fv[j] = 16'h1000;
    evaluate(fv);
    write_word(0, draw_word(SPAN_HALF));
    write_word(BIAS1_ADDR, draw_word(SPAN_HALF));
    write_word(WEIGHT2_ADDR, draw_word(SPAN_HALF));
    write_word(BIAS2_ADDR, draw_word(SPAN_HALF));
    write_word(BIAS2_ADDR + 1, draw_word(SPAN_HALF));

    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_idle[p];
      done = 0;
      while (done < PHASE_ITEMS) begin
        // leave stretches without idling inside the idle phases
        if ($urandom_range(0, 39) == 0)
          idle_pct = ($urandom_range(0, 3) == 0) ? 0 : phase_idle[p];
        if ($urandom_range(0, 5) == 0) begin
          burst = $urandom_range(2, 12);
          repeat (burst) begin
            if ($urandom_range(0, 99) < 85) write_word($urandom_range(0, LAYOUT_WORDS - 1),
                                                       random_weight());
            else write_word($urandom_range(LAYOUT_WORDS, STORE_WORDS - 1), random_weight());
          end
          done += burst;
        end else begin
          evaluate(random_features($urandom_range(0, 99)));
          done++;
        end
      end
      // hold the sender off until every pending result is back
      drain_results(4 * EVAL_LATENCY);
    end

    repeat (EVAL_LATENCY + 10) @(posedge clk);
    if (sb.pending_count() != 0) begin
      $error("%0d evaluations never produced a result", sb.pending_count());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
